>>> rtl/ddcm_pkg.sv
// Shared types and constants of the differential-drive command mixer.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ddcm_pkg;

	localparam int AddrW    = 6;
	localparam int DataW    = 64;
	localparam int SideW    = 43;  // signed side value, units 2^-24
	localparam int MagW     = 36;  // side magnitude reachable in track mode
	localparam int NumW     = 61;  // dividend of the normalization
	localparam int DivSteps = 25;  // quotient bits, quotient never above 2^24
	localparam int OutW     = 20;

	localparam logic [2:0] REG_DRIVE_MODE   = 3'd0;
	localparam logic [2:0] REG_WHEEL_BASE   = 3'd1;
	localparam logic [2:0] REG_TRACK_BASE   = 3'd2;
	localparam logic [2:0] REG_INV_RADIUS   = 3'd3;
	localparam logic [2:0] REG_TRACK_GAIN   = 3'd4;
	localparam logic [2:0] REG_DEADBAND     = 3'd5;
	localparam logic [2:0] REG_CORR_FACTORS = 3'd6;

	localparam logic [SideW-1:0] ONE_Q24 = SideW'(1) << 24;
	localparam logic [DivSteps-1:0] Q_ONE = DivSteps'(1) << 24;

	localparam logic signed [OutW-1:0] OUT_MAX = 20'sd524287;
	localparam logic signed [OutW-1:0] OUT_MIN = -20'sd524288;

	typedef struct packed {
		logic        drive_mode;
		logic [15:0] wheel_base_width;
		logic [15:0] track_base_width;
		logic [19:0] inverse_wheel_radius;
		logic [19:0] track_gain;
		logic [15:0] deadband;
		logic [63:0] correction_factors;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic                    track;
		logic                    norm;
		logic signed [SideW-1:0] left;
		logic signed [SideW-1:0] right;
		logic [SideW-1:0]        abs_l;
		logic [SideW-1:0]        abs_r;
	} side_t;

endpackage

>>> rtl/ddcm_regs.sv
// Configuration register file behind the APB-style port.
// Depends on ddcm_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module ddcm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ddcm_pkg::AddrW-1:0]  paddr,
	input  logic [ddcm_pkg::DataW-1:0]  pwdata,
	output logic [ddcm_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output ddcm_pkg::cfg_t              cfg
);

	ddcm_pkg::cfg_t cfg_q;
	logic           wr;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[5:3];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode           <= 1'b0;
			cfg_q.wheel_base_width     <= 16'd2458;
			cfg_q.track_base_width     <= 16'd2212;
			cfg_q.inverse_wheel_radius <= 20'd24824;
			cfg_q.track_gain           <= 20'd54933;
			cfg_q.deadband             <= 16'd1311;
			cfg_q.correction_factors   <= 64'h4000_4000_4000_4000;
		end else if (wr) begin
			unique case (idx)
				ddcm_pkg::REG_DRIVE_MODE:   cfg_q.drive_mode           <= pwdata[0];
				ddcm_pkg::REG_WHEEL_BASE:   cfg_q.wheel_base_width     <= pwdata[15:0];
				ddcm_pkg::REG_TRACK_BASE:   cfg_q.track_base_width     <= pwdata[15:0];
				ddcm_pkg::REG_INV_RADIUS:   cfg_q.inverse_wheel_radius <= pwdata[19:0];
				ddcm_pkg::REG_TRACK_GAIN:   cfg_q.track_gain           <= pwdata[19:0];
				ddcm_pkg::REG_DEADBAND:     cfg_q.deadband             <= pwdata[15:0];
				ddcm_pkg::REG_CORR_FACTORS: cfg_q.correction_factors   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ddcm_pkg::REG_DRIVE_MODE:   prdata = 64'(cfg_q.drive_mode);
			ddcm_pkg::REG_WHEEL_BASE:   prdata = 64'(cfg_q.wheel_base_width);
			ddcm_pkg::REG_TRACK_BASE:   prdata = 64'(cfg_q.track_base_width);
			ddcm_pkg::REG_INV_RADIUS:   prdata = 64'(cfg_q.inverse_wheel_radius);
			ddcm_pkg::REG_TRACK_GAIN:   prdata = 64'(cfg_q.track_gain);
			ddcm_pkg::REG_DEADBAND:     prdata = 64'(cfg_q.deadband);
			ddcm_pkg::REG_CORR_FACTORS: prdata = cfg_q.correction_factors;
			default:                    prdata = '0;
		endcase
	end

endmodule

>>> rtl/ddcm_front.sv
// Front pipeline: side speeds, gain multiply, rounding and larger magnitude.
// Five register stages; depends on ddcm_pkg.
`timescale 1ns / 1ps

module ddcm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [15:0]                linear_speed,
	input  logic signed [15:0]                yaw_rate,
	input  ddcm_pkg::cfg_t                    cfg,
	output ddcm_pkg::side_t                   side,
	output logic [ddcm_pkg::SideW-1:0]        max_mag
);

	logic track;
	assign track = cfg.drive_mode;

	// stage 1: yaw rate times base width
	logic [15:0]        base;
	logic signed [32:0] wb_c;
	logic               v_s1;
	logic signed [15:0] lin_s1;
	logic signed [32:0] wb_s1;

	assign base = track ? cfg.track_base_width : cfg.wheel_base_width;
	assign wb_c = 33'(yaw_rate) * $signed({17'd0, base});

	// stage 2: side speeds in units of 2^-25
	logic signed [33:0] lin_x, wb_x;
	logic               v_s2;
	logic signed [33:0] sl_s2, sr_s2;

	assign lin_x = $signed({{5{lin_s1[15]}}, lin_s1, 13'd0});
	assign wb_x  = 34'(wb_s1);

	// stage 3: gain multiply
	logic [19:0]        gain;
	logic signed [54:0] gain_x;
	logic               v_s3;
	logic signed [54:0] pl_s3, pr_s3;

	assign gain   = track ? cfg.track_gain : cfg.inverse_wheel_radius;
	assign gain_x = $signed({35'd0, gain});

	// stage 4: round to Q.24
	logic signed [54:0] tl, tr, shl, shr;
	logic               v_s4;
	logic signed [ddcm_pkg::SideW-1:0] l_s4, r_s4;

	assign tl  = pl_s3 + (track ? 55'sd65536 : 55'sd4096);
	assign tr  = pr_s3 + (track ? 55'sd65536 : 55'sd4096);
	assign shl = track ? (tl >>> 17) : (tl >>> 13);
	assign shr = track ? (tr >>> 17) : (tr >>> 13);

	// stage 5: magnitudes and the normalization decision
	logic [ddcm_pkg::SideW-1:0] al, ar, mx;
	ddcm_pkg::side_t            side_s5;
	logic [ddcm_pkg::SideW-1:0] max_s5;

	assign al = l_s4[ddcm_pkg::SideW-1] ? ddcm_pkg::SideW'(-l_s4) : ddcm_pkg::SideW'(l_s4);
	assign ar = r_s4[ddcm_pkg::SideW-1] ? ddcm_pkg::SideW'(-r_s4) : ddcm_pkg::SideW'(r_s4);
	assign mx = (al > ar) ? al : ar;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			side_s5 <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			side_s5.valid <= v_s4;
			side_s5.track <= track;
			side_s5.norm  <= track && (mx > ddcm_pkg::ONE_Q24);
			side_s5.left  <= l_s4;
			side_s5.right <= r_s4;
			side_s5.abs_l <= al;
			side_s5.abs_r <= ar;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1 <= linear_speed;
			wb_s1  <= wb_c;
			sl_s2  <= lin_x - wb_x;
			sr_s2  <= lin_x + wb_x;
			pl_s3  <= 55'(sl_s2) * gain_x;
			pr_s3  <= 55'(sr_s2) * gain_x;
			l_s4   <= shl[ddcm_pkg::SideW-1:0];
			r_s4   <= shr[ddcm_pkg::SideW-1:0];
			max_s5 <= mx;
		end
	end

	assign side    = side_s5;
	assign max_mag = max_s5;

endmodule

>>> rtl/ddcm_div.sv
// Normalization divider: |x|*2^24/max rounded, one quotient bit per stage.
// Twenty-five register stages for both sides; depends on ddcm_pkg.
`timescale 1ns / 1ps

module ddcm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  ddcm_pkg::side_t                     side_in,
	input  logic [ddcm_pkg::SideW-1:0]          max_mag,
	output ddcm_pkg::side_t                     side_out,
	output logic [ddcm_pkg::DivSteps-1:0]       q_l,
	output logic [ddcm_pkg::DivSteps-1:0]       q_r
);

	localparam int N = ddcm_pkg::DivSteps;
	localparam int Last = N - 1;

	ddcm_pkg::side_t           side_sk [N];
	logic [ddcm_pkg::MagW-1:0] m_sk    [N];
	logic [ddcm_pkg::NumW-1:0] rl_sk   [N];
	logic [ddcm_pkg::NumW-1:0] rr_sk   [N];
	logic [N-1:0]              ql_sk   [N];
	logic [N-1:0]              qr_sk   [N];

	logic [ddcm_pkg::MagW-1:0] m0;
	logic [ddcm_pkg::NumW-1:0] rl0, rr0;

	// dividend carries the half divisor for round to nearest
	assign m0  = max_mag[ddcm_pkg::MagW-1:0];
	assign rl0 = ddcm_pkg::NumW'({side_in.abs_l[ddcm_pkg::MagW-1:0], 24'd0})
		+ ddcm_pkg::NumW'(m0 >> 1);
	assign rr0 = ddcm_pkg::NumW'({side_in.abs_r[ddcm_pkg::MagW-1:0], 24'd0})
		+ ddcm_pkg::NumW'(m0 >> 1);

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int Bit = N - 1 - k;
		ddcm_pkg::side_t           s_in;
		logic [ddcm_pkg::MagW-1:0] m_in;
		logic [ddcm_pkg::NumW-1:0] rl_in, rr_in, cand;
		logic [N-1:0]              ql_in, qr_in, ql_nx, qr_nx;
		logic                      gl, gr;

		if (k == 0) begin : g_first
			assign s_in  = side_in;
			assign m_in  = m0;
			assign rl_in = rl0;
			assign rr_in = rr0;
			assign ql_in = '0;
			assign qr_in = '0;
		end else begin : g_next
			assign s_in  = side_sk[k-1];
			assign m_in  = m_sk[k-1];
			assign rl_in = rl_sk[k-1];
			assign rr_in = rr_sk[k-1];
			assign ql_in = ql_sk[k-1];
			assign qr_in = qr_sk[k-1];
		end

		assign cand = ddcm_pkg::NumW'(m_in) << Bit;
		assign gl   = rl_in >= cand;
		assign gr   = rr_in >= cand;

		always_comb begin
			ql_nx      = ql_in;
			qr_nx      = qr_in;
			ql_nx[Bit] = gl;
			qr_nx[Bit] = gr;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_sk[k] <= '0;
			end else if (en) begin
				side_sk[k] <= s_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_sk[k]  <= m_in;
				rl_sk[k] <= gl ? rl_in - cand : rl_in;
				rr_sk[k] <= gr ? rr_in - cand : rr_in;
				ql_sk[k] <= ql_nx;
				qr_sk[k] <= qr_nx;
			end
		end
	end

	assign side_out = side_sk[Last];
	assign q_l      = ql_sk[Last];
	assign q_r      = qr_sk[Last];

	logic chk;
	assign chk = side_sk[Last].valid && side_sk[Last].norm;

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chk |-> (ql_sk[Last] <= ddcm_pkg::Q_ONE) && (qr_sk[Last] <= ddcm_pkg::Q_ONE))
		else $error("normalized quotient above one");

	a_q_unit: assert property (@(posedge clk) disable iff (!arst_n)
		chk |-> (ql_sk[Last] == ddcm_pkg::Q_ONE) || (qr_sk[Last] == ddcm_pkg::Q_ONE))
		else $error("larger side did not normalize to one");

	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		chk |-> (rl_sk[Last] < ddcm_pkg::NumW'(m_sk[Last]))
			&& (rr_sk[Last] < ddcm_pkg::NumW'(m_sk[Last])))
		else $error("divider remainder not below divisor");

endmodule

>>> rtl/ddcm_out.sv
// Output pipeline: normalized select, deadband, per-motor factor, saturation.
// Three register stages ending in the output register; depends on ddcm_pkg.
`timescale 1ns / 1ps

module ddcm_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  ddcm_pkg::side_t                   side,
	input  logic [ddcm_pkg::DivSteps-1:0]     q_l,
	input  logic [ddcm_pkg::DivSteps-1:0]     q_r,
	input  ddcm_pkg::cfg_t                    cfg,
	output logic                              out_valid,
	output logic [4*ddcm_pkg::OutW-1:0]       out_data
);

	localparam int W = ddcm_pkg::SideW;

	// stage 1: pick the normalized value and apply the deadband
	logic signed [W-1:0] ql_x, qr_x, sel_l, sel_r;
	logic [W-1:0]        mag_l, mag_r, db;
	logic                v_s1;
	logic signed [W-1:0] fl_s1, fr_s1;

	assign ql_x  = $signed(W'(q_l));
	assign qr_x  = $signed(W'(q_r));
	assign sel_l = side.norm ? (side.left[W-1]  ? -ql_x : ql_x) : side.left;
	assign sel_r = side.norm ? (side.right[W-1] ? -qr_x : qr_x) : side.right;
	assign mag_l = side.norm ? W'(q_l) : side.abs_l;
	assign mag_r = side.norm ? W'(q_r) : side.abs_r;
	assign db    = W'({cfg.deadband, 8'd0});

	// stage 2: per-motor factors
	logic signed [59:0] f_x [4];
	logic               v_s2;
	logic signed [59:0] p_s2 [4];

	for (genvar k = 0; k < 4; k++) begin : g_fac
		assign f_x[k] = $signed({44'd0, cfg.correction_factors[16*k +: 16]});
	end

	// stage 3: round to Q8.12 and saturate
	logic signed [59:0]               t [4];
	logic signed [59:0]               r [4];
	logic signed [ddcm_pkg::OutW-1:0] sat [4];
	logic                             v_s3;
	logic [4*ddcm_pkg::OutW-1:0]      data_s3;

	for (genvar k = 0; k < 4; k++) begin : g_sat
		assign t[k] = p_s2[k] + 60'sd33554432;
		assign r[k] = t[k] >>> 26;
		always_comb begin
			priority if (r[k] > 60'(ddcm_pkg::OUT_MAX)) sat[k] = ddcm_pkg::OUT_MAX;
			else if (r[k] < 60'(ddcm_pkg::OUT_MIN))     sat[k] = ddcm_pkg::OUT_MIN;
			else                                         sat[k] = r[k][ddcm_pkg::OutW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= side.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1   <= (side.track && (mag_l < db)) ? '0 : sel_l;
			fr_s1   <= (side.track && (mag_r < db)) ? '0 : sel_r;
			p_s2[0] <= 60'(fl_s1) * f_x[0];
			p_s2[1] <= 60'(fl_s1) * f_x[1];
			p_s2[2] <= 60'(fr_s1) * f_x[2];
			p_s2[3] <= 60'(fr_s1) * f_x[3];
			data_s3 <= {sat[3], sat[2], sat[1], sat[0]};
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

>>> rtl/diff_drive_command_mixer.sv
// Commands pass the front, divider and output pipelines in turn.
// Throughput: one command per cycle; the whole pipeline holds while the
// output register holds an untaken word, and flows whenever it is empty.
// The 25-stage normalization divider sets the depth; no memory, no clearing.
// Reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps

module diff_drive_command_mixer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // linear_speed, yaw_rate
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// motor_left_front, motor_left_rear, motor_right_front, motor_right_rear
	output logic [79:0]                m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddcm_pkg::AddrW-1:0] paddr,
	input  logic [ddcm_pkg::DataW-1:0] pwdata,
	output logic [ddcm_pkg::DataW-1:0] prdata,
	output logic                       pready
);

	ddcm_pkg::cfg_t                 cfg;
	ddcm_pkg::side_t                side_f, side_d;
	logic [ddcm_pkg::SideW-1:0]     max_mag;
	logic [ddcm_pkg::DivSteps-1:0]  q_l, q_r;
	logic                           en;

	// advance whenever the output register is free or being emptied
	assign en       = m_tready | ~m_tvalid;
	assign s_tready = en;

	ddcm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg (cfg)
	);

	ddcm_front u_front (
		.clk, .arst_n, .en,
		.in_valid     (s_tvalid),
		.linear_speed ($signed(s_tdata[15:0])),
		.yaw_rate     ($signed(s_tdata[31:16])),
		.cfg          (cfg),
		.side         (side_f),
		.max_mag      (max_mag)
	);

	ddcm_div u_div (
		.clk, .arst_n, .en,
		.side_in  (side_f),
		.max_mag  (max_mag),
		.side_out (side_d),
		.q_l      (q_l),
		.q_r      (q_r)
	);

	ddcm_out u_out (
		.clk, .arst_n, .en,
		.side      (side_d),
		.q_l       (q_l),
		.q_r       (q_r),
		.cfg       (cfg),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule
